// ===== hdl/pur_pkg.sv =====
// Shared types and codes for the polled UART receive-ring device.
// No dependencies; used by polled_uart_rx_ring_device.
`default_nettype none

package pur_pkg;

   typedef enum logic [2:0] {
      KIND_RX_BYTE      = 3'd0,
      KIND_STATUS_READ  = 3'd1,
      KIND_STATUS_WRITE = 3'd2,
      KIND_RXDATA_READ  = 3'd3,
      KIND_TXDATA_WRITE = 3'd4,
      KIND_CONNECT      = 3'd5,
      KIND_DISCONNECT   = 3'd6
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       tx_valid;
      logic [7:0] tx_byte;
   } rsp_type;

   // Ring entry returned by a data read while the ring is empty.
   localparam int EMPTY_READ_ENTRY = 3;

endpackage

`default_nettype wire

// ===== hdl/polled_uart_rx_ring_device.sv =====
// Polled UART with a receive ring: event decode, ring memory, result register.
// Depends on pur_pkg (req_type, rsp_type, kind_type, EMPTY_READ_ENTRY).
//
//  channel | ports                          | beat
//  --------+--------------------------------+------------------------------
//  request | req_valid, req_stall, req_data | one event (kind, data)
//  result  | rsp_valid, rsp_stall, rsp_data | read_data, tx_valid, tx_byte
//
// One event is taken per cycle while req_stall is low; its result passes the read stage, then the output register.
// The ring memory has one write and one registered read port; each event uses
// at most one of them, so with no stall the rate is one event per cycle.
// After reset the ring is zeroed, one entry per cycle, with req_stall high until
// the last entry is written.
// A stalled result holds in the output register; one more event can sit in
// the memory-read stage behind it before req_stall rises.
`default_nettype none

module polled_uart_rx_ring_device #(
   parameter int RING_DEPTH   = 64,
   parameter int RX_AVAIL_BIT = 0,
   parameter int TX_BUSY_BIT  = 1,
   parameter int RESET_BIT    = 2
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire pur_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output pur_pkg::rsp_type rsp_data
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
   localparam logic [IDX_W-1:0] EMPTY_IDX =
      IDX_W'(pur_pkg::EMPTY_READ_ENTRY % RING_DEPTH);

   typedef struct packed {
      pur_pkg::rsp_type pre;
      logic             mem_rd;
   } stage_type;

   logic [7:0] ring_mem [RING_DEPTH];
   logic [7:0] mem_q_ff;

   logic [IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0] wr_idx_ff, wr_idx_in;
   logic             has_data_ff, has_data_in;
   logic             link_up_ff, link_up_in;
   logic             clearing_ff, clearing_in;
   logic [IDX_W-1:0] clr_idx_ff, clr_idx_in;

   logic             s1_valid_ff, s1_valid_in;
   stage_type        s1_ff, s1_in;
   logic             out_valid_ff, out_valid_in;
   pur_pkg::rsp_type out_ff, out_in;

   logic             req_accept;
   logic             out_free;
   logic             s1_move;
   logic             mem_we, mem_re;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   logic [7:0]       mem_wdata;
   logic [7:0]       status;
   logic [IDX_W-1:0] rd_next;
   logic [IDX_W-1:0] wr_next;

   assign out_free   = !out_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_free;
   assign req_stall  = clearing_ff || (s1_valid_ff && !out_free);
   assign req_accept = req_valid && !req_stall;

   assign rd_next = (rd_idx_ff == LAST_IDX) ? '0 : rd_idx_ff + 1'b1;
   assign wr_next = (wr_idx_ff == LAST_IDX) ? '0 : wr_idx_ff + 1'b1;

   always_comb begin
      status = '0;
      status[RX_AVAIL_BIT[2:0]] = has_data_ff;
      status[TX_BUSY_BIT[2:0]]  = status[TX_BUSY_BIT[2:0]] | !link_up_ff;
   end

   // Event decode and post-reset clearing: next state, memory port controls, early result.
   always_comb begin
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      has_data_in = has_data_ff;
      link_up_in  = link_up_ff;
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      mem_we      = 1'b0;
      mem_waddr   = wr_idx_ff;
      mem_wdata   = req_data.data;
      mem_re      = 1'b0;
      mem_raddr   = has_data_ff ? rd_idx_ff : EMPTY_IDX;
      s1_in       = '0;
      if (clearing_ff) begin
         mem_we     = 1'b1;
         mem_waddr  = clr_idx_ff;
         mem_wdata  = '0;
         clr_idx_in = clr_idx_ff + 1'b1;
         if (clr_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end else if (req_accept) begin
         case (req_data.kind)
            pur_pkg::KIND_RX_BYTE: begin
               mem_we      = 1'b1;
               has_data_in = 1'b1;
               wr_idx_in   = wr_next;
               if (!has_data_ff) begin
                  rd_idx_in = wr_idx_ff;
               end
            end
            pur_pkg::KIND_STATUS_READ: begin
               s1_in.pre.read_data = status;
            end
            pur_pkg::KIND_STATUS_WRITE: begin
               if (req_data.data[RESET_BIT[2:0]]) begin
                  has_data_in = 1'b0;
                  rd_idx_in   = '0;
                  wr_idx_in   = '0;
               end
            end
            pur_pkg::KIND_RXDATA_READ: begin
               mem_re       = 1'b1;
               s1_in.mem_rd = 1'b1;
               if (has_data_ff) begin
                  rd_idx_in = rd_next;
                  if (rd_next == wr_idx_ff) begin
                     has_data_in = 1'b0;
                  end
               end
            end
            pur_pkg::KIND_TXDATA_WRITE: begin
               if (link_up_ff) begin
                  s1_in.pre.tx_valid = 1'b1;
                  s1_in.pre.tx_byte  = req_data.data;
               end
            end
            pur_pkg::KIND_CONNECT: begin
               link_up_in = 1'b1;
            end
            pur_pkg::KIND_DISCONNECT: begin
               link_up_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_accept || (s1_valid_ff && !s1_move);
      out_valid_in = s1_move || (out_valid_ff && rsp_stall);
      out_in       = s1_ff.pre;
      if (s1_ff.mem_rd) begin
         out_in.read_data = mem_q_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= ring_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         has_data_ff  <= 1'b0;
         link_up_ff   <= 1'b0;
         clearing_ff  <= 1'b1;
         clr_idx_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         has_data_ff  <= has_data_in;
         link_up_ff   <= link_up_in;
         clearing_ff  <= clearing_in;
         clr_idx_ff   <= clr_idx_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff <= s1_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (int'(rd_idx_ff) < RING_DEPTH) && (int'(wr_idx_ff) < RING_DEPTH))
      else $error("ring index out of range");

   a_rx_sets_data: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.kind == pur_pkg::KIND_RX_BYTE) |=> has_data_ff)
      else $error("received byte left ring empty");

   a_status_reset: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.kind == pur_pkg::KIND_STATUS_WRITE
       && req_data.data[RESET_BIT[2:0]])
      |=> (!has_data_ff && wr_idx_ff == '0 && rd_idx_ff == '0))
      else $error("status reset did not empty ring");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_move) |=> (s1_valid_ff && $stable(s1_ff)))
      else $error("blocked beat lost in read stage");

endmodule

`default_nettype wire
